>>> hw/rtl/itda_pkg.sv
package itda_pkg;

    // width of the input word
    localparam int WORD_BITS = 16;
    // decimal digits needed for the largest word, floor(n*log10(2)) + 1
    localparam int DIGITS    = ((WORD_BITS * 1233) >> 12) + 1;
    localparam int BCD_W     = DIGITS * 4;
    localparam int CNT_W     = $clog2(WORD_BITS + 1);

    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_EMIT
    } itda_state_t;

    typedef struct packed {
        logic                 func;
        logic [WORD_BITS-1:0] value;
    } itda_in_t;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last;
    } itda_out_t;

    // double-dabble correction: add 3 to every digit of 5 or more
    function automatic logic [BCD_W-1:0] bcd_add3(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        logic [3:0]       dig;
        res = bcd;
        for (int i = 0; i < DIGITS; i++)
        begin
            dig = bcd[i*4 +: 4];
            if (dig >= 4'd5)
            begin
                res[i*4 +: 4] = dig + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/int_to_decimal_ascii_unit.sv
// Binary word to decimal ASCII text. Each input beat carries a WORD_BITS-bit
// word and a func bit (0 = unsigned, 1 = two's complement signed). The unit
// returns the decimal text one character per output beat, most significant
// digit first, with no leading zeros; zero gives a single '0', a negative
// value gives '-' then the magnitude (the most negative word converts
// correctly), and the final character of each number has last set. An item
// passes through the serial double-dabble converter's shift-and-correct
// steps, then leading zero digits are dropped, then the text goes out one
// character per cycle while the sink is ready. in_ready is high only while
// the unit is idle. The last character sits in its own output register, so
// the next item is taken while that character is still held.
module int_to_decimal_ascii_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  itda_pkg::itda_in_t  in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output itda_pkg::itda_out_t out_beat
);
    import itda_pkg::*;

    itda_state_t          state_reg, state_next;
    logic [WORD_BITS-1:0] bin_reg, bin_next;      // binary bits still to shift in
    logic [BCD_W-1:0]     bcd_reg, bcd_next;      // packed bcd digits, msd on top
    logic [CNT_W-1:0]     cnt_reg, cnt_next;      // bit count, then digit count
    logic                 neg_reg, neg_next;      // minus sign still to send
    logic                 out_valid_reg, out_valid_next;
    itda_out_t            out_reg, out_next;

    logic                 in_fire;
    logic                 out_load;               // output register free this cycle
    logic                 cnt_one;
    logic                 in_neg;
    logic [WORD_BITS-1:0] in_mag;
    logic [BCD_W-1:0]     bcd_adj;
    logic [3:0]           top_digit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_load  = !out_valid_reg || out_ready;
    assign cnt_one   = (cnt_reg == CNT_W'(1));
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign bcd_adj   = bcd_add3(bcd_reg);

    // sign and magnitude at word width, so the most negative word has no overflow
    assign in_neg = in_beat.func && in_beat.value[WORD_BITS-1];
    assign in_mag = in_neg ? WORD_BITS'(~in_beat.value + WORD_BITS'(1)) : in_beat.value;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (cnt_one)
                begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                // stop at the first nonzero digit, or keep a single zero
                if (top_digit != 4'd0 || cnt_one)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // final digit goes out, the sign never ends the text
                if (out_load && !neg_reg && cnt_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output register
    always_comb
    begin
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    bin_next = in_mag;
                    bcd_next = '0;
                    cnt_next = CNT_W'(WORD_BITS);
                    neg_next = in_neg;
                end
            end
            ST_CONV:
            begin
                // correct every digit, then shift one binary bit in
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[WORD_BITS-1]};
                bin_next = {bin_reg[WORD_BITS-2:0], 1'b0};
                cnt_next = cnt_one ? CNT_W'(DIGITS) : cnt_reg - CNT_W'(1);
            end
            ST_STRIP:
            begin
                if (top_digit == 4'd0 && !cnt_one)
                begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (neg_reg)
                    begin
                        out_next.ascii_char = CH_MINUS;
                        out_next.last       = 1'b0;
                        neg_next            = 1'b0;
                    end
                    else
                    begin
                        out_next.ascii_char = CH_ZERO + {4'd0, top_digit};
                        out_next.last       = cnt_one;
                        bcd_next            = {bcd_reg[BCD_W-5:0], 4'd0};
                        cnt_next            = cnt_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            neg_reg       <= neg_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

endmodule

>>> sim/int_to_decimal_ascii_unit_tb.sv
`timescale 1ns / 1ps

module int_to_decimal_ascii_unit_tb;

    import itda_pkg::*;

    // stimulus sizes and run limits
    localparam int RANDOM_ITEMS = 106;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    // receiver stall patterns
    localparam int RX_STEADY = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SLOW   = 2;

    // one word waiting to be sent; hold_for_drain makes the sender wait
    // until every character already predicted has come back
    typedef struct {
        itda_in_t word;
        logic     hold_for_drain;
    } pending_word_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    itda_in_t  in_beat   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    itda_out_t out_beat;

    pending_word_t pending_words [$];
    itda_out_t     expected_chars [$];

    int mismatch_count  = 0;
    int chars_predicted = 0;
    int chars_seen      = 0;
    int cycle_count     = 0;

    // sender burst shaping, touched only by the driver
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall shaping, touched only by the ready process
    int rx_mode     = RX_STEADY;
    int rx_seg_left = 0;
    int rx_hold     = 0;

    int_to_decimal_ascii_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    always #2 clk = ~clk;

    // decimal text of one word, appended to the expected characters
    function automatic void predict_text(input itda_in_t word_in);
        logic [WORD_BITS-1:0] mag;
        logic [3:0]           digit_buf [0:15];
        int                   n;
        logic                 neg;
        itda_out_t            ch;
        // sign only counts in signed mode
        neg = word_in.func && word_in.value[WORD_BITS-1];
        // two's complement magnitude at word width, so the most negative
        // word comes out as its unsigned pattern
        mag = neg ? (~word_in.value + 1'b1) : word_in.value;
        // least significant digit first; zero still yields one digit
        n = 0;
        do
        begin
            digit_buf[n] = 4'(mag % 10);
            mag          = WORD_BITS'(mag / 10);
            n++;
        end
        while (mag != 0);
        if (neg)
        begin
            ch.ascii_char = CH_MINUS;
            ch.last       = 1'b0;
            expected_chars.push_back(ch);
            chars_predicted++;
        end
        // emit most significant first, last flag on the units digit
        for (int i = n - 1; i >= 0; i--)
        begin
            ch.ascii_char = CH_ZERO + digit_buf[i];
            ch.last       = (i == 0);
            expected_chars.push_back(ch);
            chars_predicted++;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic add_word(input logic func, input logic [WORD_BITS-1:0] value,
                            input logic hold);
        pending_word_t p;
        p.word.func      = func;
        p.word.value     = value;
        p.hold_for_drain = hold;
        pending_words.push_back(p);
    endtask

    // driver: valid stays up with a stable payload until the unit takes it,
    // and new words go out in bursts separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic          next_valid;
        logic          may_send;
        pending_word_t head;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_beat  <= '0;
        end
        else
        begin
            next_valid = in_valid;
            // accepted beat: predict its text from the payload just taken
            if (in_valid && in_ready)
            begin
                predict_text(in_beat);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                // chars_seen is the monitor's registered count, so this
                // drain test does not depend on process order
                may_send = pending_words.size() != 0 &&
                           (!pending_words[0].hold_for_drain ||
                            chars_predicted == chars_seen);
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (may_send)
                begin
                    head       = pending_words.pop_front();
                    in_beat   <= head.word;
                    next_valid = 1'b1;
                    if (burst_left <= 1)
                    begin
                        // new burst; about a quarter of gaps are zero so
                        // there are stretches with no sender idling
                        burst_left = $urandom_range(1, 8);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(1, 3);
                            2:       gap_left = $urandom_range(4, 15);
                            default: gap_left = $urandom_range(16, 40);
                        endcase
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
            in_valid <= next_valid;
        end
    end

    // receiver ready pattern: segments of always ready, coin flips, and
    // long stalls with short windows of ready
    always @(posedge clk or negedge rst_n)
    begin : ready_proc
        logic next_ready;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_seg_left == 0)
            begin
                rx_mode     = $urandom_range(RX_STEADY, RX_SLOW);
                rx_seg_left = $urandom_range(10, 80);
                rx_hold     = 0;
            end
            else
            begin
                rx_seg_left--;
            end
            case (rx_mode)
                RX_STEADY: next_ready = 1'b1;
                RX_COIN:   next_ready = 1'($urandom_range(0, 1));
                default:
                begin
                    if (rx_hold != 0)
                    begin
                        rx_hold--;
                        next_ready = out_ready;
                    end
                    else
                    begin
                        // flip, then hold: long lows, short highs
                        next_ready = !out_ready;
                        rx_hold    = next_ready ? $urandom_range(0, 2)
                                                : $urandom_range(1, 12);
                    end
                end
            endcase
            out_ready <= next_ready;
        end
    end

    // monitor: every accepted character against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        itda_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            chars_seen <= chars_seen + 1;
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                          out_beat.ascii_char, out_beat.last));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_beat.ascii_char !== want.ascii_char)
                begin
                    report_mismatch($sformatf("ascii_char got 0x%02h want 0x%02h",
                                              out_beat.ascii_char, want.ascii_char));
                end
                if (out_beat.last !== want.last)
                begin
                    report_mismatch($sformatf("last got %0b want %0b on char 0x%02h",
                                              out_beat.last, want.last, want.ascii_char));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus_proc
        logic [WORD_BITS-1:0] min_neg;
        logic [WORD_BITS-1:0] max_pos;
        logic [WORD_BITS-1:0] v;
        logic [WORD_BITS-1:0] base;
        logic                 f;
        int                   pow10;
        min_neg = {1'b1, {(WORD_BITS-1){1'b0}}};
        max_pos = {1'b0, {(WORD_BITS-1){1'b1}}};

        // directed: zero in both modes, digit count boundaries, extremes
        add_word(1'b0, '0, 1'b0);
        add_word(1'b1, '0, 1'b0);
        add_word(1'b0, 1, 1'b0);
        add_word(1'b1, 1, 1'b0);
        add_word(1'b0, 9, 1'b0);
        add_word(1'b0, 10, 1'b0);
        add_word(1'b1, 9, 1'b0);
        add_word(1'b0, 99, 1'b0);
        add_word(1'b0, 100, 1'b0);
        add_word(1'b0, 999, 1'b0);
        add_word(1'b0, 1000, 1'b0);
        add_word(1'b0, 9999, 1'b0);
        add_word(1'b0, 10000, 1'b0);
        add_word(1'b0, '1, 1'b0);
        add_word(1'b1, '1, 1'b0);
        // most negative word, sent into an empty pipe
        add_word(1'b1, min_neg, 1'b1);
        add_word(1'b0, min_neg, 1'b0);
        add_word(1'b1, max_pos, 1'b0);
        add_word(1'b0, max_pos, 1'b0);
        add_word(1'b1, min_neg + 1'b1, 1'b0);
        add_word(1'b1, WORD_BITS'(-10), 1'b0);
        add_word(1'b1, WORD_BITS'(-9), 1'b0);
        add_word(1'b0, 12345, 1'b0);
        add_word(1'b1, WORD_BITS'(-12345), 1'b0);

        // random: full words, small numbers, near powers of ten, near extremes
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            f = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0: v = WORD_BITS'($urandom_range(0, 20));
                1:
                begin
                    pow10 = 1;
                    repeat ($urandom_range(0, 4)) pow10 = pow10 * 10;
                    v = WORD_BITS'(pow10 + $urandom_range(0, 2) - 1);
                    if (f && $urandom_range(0, 1))
                    begin
                        v = -v;
                    end
                end
                2:
                begin
                    case ($urandom_range(0, 2))
                        0:       base = '0;
                        1:       base = min_neg;
                        default: base = '1;
                    endcase
                    v = WORD_BITS'(base + $urandom_range(0, 4) - 2);
                end
                default: v = WORD_BITS'($urandom);
            endcase
            add_word(f, v, i == RANDOM_ITEMS / 2);
        end

        // single reset at the start
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for every word to go out and every character to return
        while (pending_words.size() != 0 || in_valid || expected_chars.size() != 0)
        begin
            @(negedge clk);
        end
        // catch stray characters after the last expected one
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
